// ===== hdl/ffpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_pkg
// Types and constants shared by the page extent allocator modules.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int PAGE_W  = 52;
    localparam int COUNT_W = 29;

    localparam logic [PAGE_W-1:0]  RESET_BASE_PAGE    = 52'hFFFF8_8000_0000;
    localparam logic [COUNT_W-1:0] RESET_REGION_PAGES = 29'h1000_0000;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_TOO_FEW  = 3'd2;
    localparam logic [2:0] ST_NO_FIT   = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    // commands and register indexes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;
    localparam logic REG_REGION_BASE  = 1'b0;
    localparam logic REG_REGION_PAGES = 1'b1;

    // one extent table entry
    typedef struct packed {
        logic [PAGE_W-1:0]  base;
        logic [COUNT_W-1:0] len;
    } ext_t;

endpackage

// ===== hdl/ffpa_ext_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_ext_ram
// Extent table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffpa_ext_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  ffpa_pkg::ext_t     wdata,
    input  logic [AW-1:0]      raddr,
    output ffpa_pkg::ext_t     rdata
);

    ffpa_pkg::ext_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/first_fit_page_extent_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_page_extent_allocator
// First-fit page extent allocator with address-sorted, coalescing free list.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one word
// comes back on status/granted_base_page/free_total with done high for one
// cycle, and the receiver must take it then. Requests rejected on the count
// check (zero, too few pages) answer from idle without raising busy.
// Everything else is walked by one sequencer over two extent memories, each
// with one write port and one registered read port. An allocate scans free
// entries up to the first fit and, on an exact fit, shifts the entries above
// it down, so scan and shift cover the table once. A free scans and shifts
// the used table once and the free table once the same way. Busy stays high
// meanwhile. No clearing pass is needed after reset or a region write.
// Configuration writes are taken only while idle.
// ----------------------------------------------------------------------------
module first_fit_page_extent_allocator #(
    parameter int MAX_EXTENTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [28:0] page_count,
    input  logic [51:0] base_page,
    output logic        done,
    output logic [2:0]  status,
    output logic [51:0] granted_base_page,
    output logic [28:0] free_total,
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [51:0] cfg_data
);

    localparam int AW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EXTENTS);

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_ARD    = 16'h0002,
        S_ACK    = 16'h0004,
        S_FRM_RD = 16'h0008,
        S_FRM_WR = 16'h0010,
        S_UWR    = 16'h0020,
        S_URD    = 16'h0040,
        S_UCK    = 16'h0080,
        S_PRD    = 16'h0100,
        S_PCK    = 16'h0200,
        S_MERGE  = 16'h0400,
        S_INS_RD = 16'h0800,
        S_INS_WR = 16'h1000,
        S_USH_RD = 16'h2000,
        S_USH_WR = 16'h4000,
        S_SPARE  = 16'h8000
    } state_t;

    state_t            state_reg;
    logic [51:0]       region_base_reg;
    logic [28:0]       region_pages_reg;
    logic [CW-1:0]     fcnt_reg;
    logic [CW-1:0]     ucnt_reg;
    logic [28:0]       total_reg;
    logic              e0_sub_reg;
    logic              fsub_reg;
    logic              cmd_reg;
    logic [28:0]       n_reg;
    logic [51:0]       b_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     pos_reg;
    logic [CW-1:0]     j_reg;
    logic [28:0]       len_reg;
    logic [51:0]       gb_reg;
    ffpa_pkg::ext_t    prev_reg;
    ffpa_pkg::ext_t    nxt_reg;
    logic              nxt_valid_reg;
    logic              done_reg;
    logic [2:0]        status_reg;
    logic [51:0]       granted_reg;
    logic [28:0]       free_total_reg;

    logic              f_we;
    logic [AW-1:0]     f_waddr;
    ffpa_pkg::ext_t    f_wdata;
    logic [AW-1:0]     f_raddr;
    ffpa_pkg::ext_t    f_ram_rd;
    ffpa_pkg::ext_t    f_rd;
    logic              u_we;
    logic [AW-1:0]     u_waddr;
    ffpa_pkg::ext_t    u_wdata;
    logic [AW-1:0]     u_raddr;
    ffpa_pkg::ext_t    u_rd;

    logic [CW-1:0]     idx_inc;
    logic [CW-1:0]     idx_dec;
    logic              fit;
    logic              prev_adj;
    logic              next_adj;

    ffpa_ext_ram #(.DEPTH(MAX_EXTENTS), .AW(AW)) u_free_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_ram_rd)
    );

    ffpa_ext_ram #(.DEPTH(MAX_EXTENTS), .AW(AW)) u_used_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .raddr (u_raddr),
        .rdata (u_rd)
    );

    // free entry 0 reads as the region until the memory holds it
    always_comb
    begin
        if (fsub_reg)
        begin
            f_rd.base = region_base_reg;
            f_rd.len  = region_pages_reg;
        end
        else
        begin
            f_rd = f_ram_rd;
        end
    end

    assign idx_inc  = CW'(idx_reg + 1'b1);
    assign idx_dec  = CW'(idx_reg - 1'b1);
    assign fit      = (f_rd.len >= n_reg);
    assign prev_adj = (idx_reg != '0) &&
                      (52'(prev_reg.base + 52'(prev_reg.len)) == b_reg);
    assign next_adj = nxt_valid_reg && (52'(b_reg + 52'(len_reg)) == nxt_reg.base);

    // memory port control
    always_comb
    begin
        f_we    = 1'b0;
        f_waddr = idx_reg[AW-1:0];
        f_wdata = f_rd;
        f_raddr = idx_reg[AW-1:0];
        u_we    = 1'b0;
        u_waddr = idx_reg[AW-1:0];
        u_wdata = u_rd;
        u_raddr = idx_reg[AW-1:0];
        unique case (state_reg)
            S_ACK:
            begin
                if (fit && (ucnt_reg != MAX_CNT) && (f_rd.len != n_reg))
                begin
                    f_we         = 1'b1;
                    f_wdata.base = 52'(f_rd.base + 52'(n_reg));
                    f_wdata.len  = 29'(f_rd.len - n_reg);
                end
            end
            S_FRM_RD: f_raddr = idx_inc[AW-1:0];
            S_FRM_WR: f_we = 1'b1;
            S_UWR:
            begin
                u_we         = 1'b1;
                u_waddr      = ucnt_reg[AW-1:0];
                u_wdata.base = gb_reg;
                u_wdata.len  = n_reg;
            end
            S_MERGE:
            begin
                if (prev_adj)
                begin
                    f_we         = 1'b1;
                    f_waddr      = idx_dec[AW-1:0];
                    f_wdata.base = prev_reg.base;
                    if (next_adj)
                    begin
                        f_wdata.len = 29'(prev_reg.len + len_reg + nxt_reg.len);
                    end
                    else
                    begin
                        f_wdata.len = 29'(prev_reg.len + len_reg);
                    end
                end
                else if (next_adj)
                begin
                    f_we         = 1'b1;
                    f_wdata.base = b_reg;
                    f_wdata.len  = 29'(nxt_reg.len + len_reg);
                end
            end
            S_INS_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    f_we         = 1'b1;
                    f_wdata.base = b_reg;
                    f_wdata.len  = len_reg;
                end
                else
                begin
                    f_raddr = idx_dec[AW-1:0];
                end
            end
            S_INS_WR: f_we = 1'b1;
            S_USH_RD: u_raddr = idx_inc[AW-1:0];
            S_USH_WR: u_we = 1'b1;
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            region_base_reg  <= ffpa_pkg::RESET_BASE_PAGE;
            region_pages_reg <= ffpa_pkg::RESET_REGION_PAGES;
            fcnt_reg         <= CW'(1);
            ucnt_reg         <= '0;
            total_reg        <= ffpa_pkg::RESET_REGION_PAGES;
            e0_sub_reg       <= 1'b1;
            fsub_reg         <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            fsub_reg <= e0_sub_reg && (f_raddr == '0);
            if (f_we && (f_waddr == '0))
            begin
                e0_sub_reg <= 1'b0;
            end
            if (cfg_we && (state_reg == S_IDLE))
            begin
                if (cfg_idx == ffpa_pkg::REG_REGION_BASE)
                begin
                    region_base_reg <= cfg_data;
                    fcnt_reg        <= CW'(region_pages_reg != '0);
                    total_reg       <= region_pages_reg;
                end
                else
                begin
                    region_pages_reg <= cfg_data[28:0];
                    fcnt_reg         <= CW'(cfg_data[28:0] != '0);
                    total_reg        <= cfg_data[28:0];
                end
                ucnt_reg   <= '0;
                e0_sub_reg <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg <= command;
                        n_reg   <= page_count;
                        b_reg   <= base_page;
                        idx_reg <= '0;
                        if (command == ffpa_pkg::CMD_FREE)
                        begin
                            state_reg <= S_URD;
                        end
                        else if (page_count == '0)
                        begin
                            done_reg       <= 1'b1;
                            status_reg     <= ffpa_pkg::ST_ZERO;
                            granted_reg    <= '0;
                            free_total_reg <= total_reg;
                        end
                        else if (page_count > total_reg)
                        begin
                            done_reg       <= 1'b1;
                            status_reg     <= ffpa_pkg::ST_TOO_FEW;
                            granted_reg    <= '0;
                            free_total_reg <= total_reg;
                        end
                        else
                        begin
                            state_reg <= S_ARD;
                        end
                    end
                end
                S_ARD:
                begin
                    if (idx_reg == fcnt_reg)
                    begin
                        done_reg       <= 1'b1;
                        status_reg     <= ffpa_pkg::ST_NO_FIT;
                        granted_reg    <= '0;
                        free_total_reg <= total_reg;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_ACK;
                    end
                end
                S_ACK:
                begin
                    if (!fit)
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_ARD;
                    end
                    else if (ucnt_reg == MAX_CNT)
                    begin
                        done_reg       <= 1'b1;
                        status_reg     <= ffpa_pkg::ST_FULL;
                        granted_reg    <= '0;
                        free_total_reg <= total_reg;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        gb_reg    <= f_rd.base;
                        state_reg <= (f_rd.len == n_reg) ? S_FRM_RD : S_UWR;
                    end
                end
                S_FRM_RD:
                begin
                    if (idx_inc >= fcnt_reg)
                    begin
                        fcnt_reg <= CW'(fcnt_reg - 1'b1);
                        if (cmd_reg == ffpa_pkg::CMD_ALLOC)
                        begin
                            state_reg <= S_UWR;
                        end
                        else
                        begin
                            idx_reg   <= j_reg;
                            state_reg <= S_USH_RD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_FRM_WR;
                    end
                end
                S_FRM_WR:
                begin
                    idx_reg   <= idx_inc;
                    state_reg <= S_FRM_RD;
                end
                S_UWR:
                begin
                    ucnt_reg       <= CW'(ucnt_reg + 1'b1);
                    total_reg      <= 29'(total_reg - n_reg);
                    done_reg       <= 1'b1;
                    status_reg     <= ffpa_pkg::ST_OK;
                    granted_reg    <= gb_reg;
                    free_total_reg <= 29'(total_reg - n_reg);
                    state_reg      <= S_IDLE;
                end
                S_URD:
                begin
                    if (idx_reg == ucnt_reg)
                    begin
                        done_reg       <= 1'b1;
                        status_reg     <= ffpa_pkg::ST_UNKNOWN;
                        granted_reg    <= '0;
                        free_total_reg <= total_reg;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_UCK;
                    end
                end
                S_UCK:
                begin
                    if (u_rd.base == b_reg)
                    begin
                        j_reg         <= idx_reg;
                        len_reg       <= u_rd.len;
                        idx_reg       <= '0;
                        nxt_valid_reg <= 1'b0;
                        state_reg     <= S_PRD;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_URD;
                    end
                end
                S_PRD:
                begin
                    state_reg <= (idx_reg == fcnt_reg) ? S_MERGE : S_PCK;
                end
                S_PCK:
                begin
                    if (f_rd.base > b_reg)
                    begin
                        nxt_reg       <= f_rd;
                        nxt_valid_reg <= 1'b1;
                        state_reg     <= S_MERGE;
                    end
                    else
                    begin
                        prev_reg  <= f_rd;
                        idx_reg   <= idx_inc;
                        state_reg <= S_PRD;
                    end
                end
                S_MERGE:
                begin
                    if (prev_adj && next_adj)
                    begin
                        state_reg <= S_FRM_RD;
                    end
                    else if (prev_adj || next_adj)
                    begin
                        idx_reg   <= j_reg;
                        state_reg <= S_USH_RD;
                    end
                    else if (fcnt_reg == MAX_CNT)
                    begin
                        done_reg       <= 1'b1;
                        status_reg     <= ffpa_pkg::ST_FULL;
                        granted_reg    <= '0;
                        free_total_reg <= total_reg;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        pos_reg   <= idx_reg;
                        idx_reg   <= fcnt_reg;
                        state_reg <= S_INS_RD;
                    end
                end
                S_INS_RD:
                begin
                    if (idx_reg == pos_reg)
                    begin
                        fcnt_reg  <= CW'(fcnt_reg + 1'b1);
                        idx_reg   <= j_reg;
                        state_reg <= S_USH_RD;
                    end
                    else
                    begin
                        state_reg <= S_INS_WR;
                    end
                end
                S_INS_WR:
                begin
                    idx_reg   <= idx_dec;
                    state_reg <= S_INS_RD;
                end
                S_USH_RD:
                begin
                    if (idx_inc >= ucnt_reg)
                    begin
                        ucnt_reg       <= CW'(ucnt_reg - 1'b1);
                        total_reg      <= 29'(total_reg + len_reg);
                        done_reg       <= 1'b1;
                        status_reg     <= ffpa_pkg::ST_OK;
                        granted_reg    <= '0;
                        free_total_reg <= 29'(total_reg + len_reg);
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_USH_WR;
                    end
                end
                S_USH_WR:
                begin
                    idx_reg   <= idx_inc;
                    state_reg <= S_USH_RD;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy              = (state_reg != S_IDLE);
    assign done              = done_reg;
    assign status            = status_reg;
    assign granted_base_page = granted_reg;
    assign free_total        = free_total_reg;

`ifndef SYNTH
    a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= MAX_CNT)
        else $error("free extent count over table size");

    a_ucnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ucnt_reg <= MAX_CNT)
        else $error("used extent count over table size");

    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg != ffpa_pkg::ST_OK)) |-> (granted_reg == '0))
        else $error("grant on rejected request");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy || $past(state_reg == S_IDLE))
        else $error("result word while sequencer still active");
`endif

endmodule

// ===== tb/sv/first_fit_page_extent_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_page_extent_allocator_tb
// Self-checking bench for the first-fit page extent allocator. A directed
// table runs first. Then several region settings follow, each with random
// allocate/free traffic, some with sender idling, and last a fragmentation
// run that fills both extent tables. Typed rows are checked against their
// own word, others against an in-bench model of the free and used tables.
// ----------------------------------------------------------------------------
module first_fit_page_extent_allocator_tb;

    localparam int NEXT    = 64;
    localparam int PAGE_W  = ffpa_pkg::PAGE_W;
    localparam int COUNT_W = ffpa_pkg::COUNT_W;

    typedef struct {
        logic [2:0]         st;
        logic [PAGE_W-1:0]  gb;
        logic [COUNT_W-1:0] fp;
    } word_t;

    typedef struct {
        logic               cmd;
        logic [COUNT_W-1:0] cnt;
        logic [PAGE_W-1:0]  base;
        bit                 typed;
        word_t              w;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               command = ffpa_pkg::CMD_ALLOC;
    logic [28:0]        page_count = '0;
    logic [51:0]        base_page = '0;
    logic               done;
    logic [2:0]         status;
    logic [51:0]        granted_base_page;
    logic [28:0]        free_total;
    logic               cfg_we = 1'b0;
    logic               cfg_idx = ffpa_pkg::REG_REGION_BASE;
    logic [51:0]        cfg_data = '0;

    // extent table model
    logic [PAGE_W-1:0]  rgn_base;
    logic [COUNT_W-1:0] rgn_pages;
    logic [PAGE_W-1:0]  fx_base [NEXT];
    logic [COUNT_W-1:0] fx_len [NEXT];
    int                 fx_cnt;
    logic [PAGE_W-1:0]  ux_base [NEXT];
    logic [COUNT_W-1:0] ux_len [NEXT];
    int                 ux_cnt;
    logic [COUNT_W-1:0] pages_free;

    word_t              pending_q[$];
    int                 n_err = 0;
    int                 n_sent = 0;
    int                 n_seen = 0;
    int                 st_hits [8];
    int                 idle_pct = 0;

    always #5 clk = ~clk;

    first_fit_page_extent_allocator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .page_count(page_count), .base_page(base_page),
        .done(done), .status(status), .granted_base_page(granted_base_page),
        .free_total(free_total), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data)
    );

    function automatic void tables_init();
        ux_cnt = 0;
        fx_cnt = (rgn_pages == 0) ? 0 : 1;
        fx_base[0] = rgn_base;
        fx_len[0] = rgn_pages;
        pages_free = rgn_pages;
    endfunction

    function automatic word_t alloc_pages(logic [COUNT_W-1:0] n);
        word_t r;
        int i;
        r.st = ffpa_pkg::ST_OK;
        r.gb = '0;
        i = 0;
        if (n == 0)
            r.st = ffpa_pkg::ST_ZERO;
        else if (n > pages_free)
            r.st = ffpa_pkg::ST_TOO_FEW;
        else
        begin
            while (i < fx_cnt && fx_len[i] < n)
                i++;
            if (i >= fx_cnt)
                r.st = ffpa_pkg::ST_NO_FIT;
            else if (ux_cnt >= NEXT)
                r.st = ffpa_pkg::ST_FULL;
        end
        if (r.st == ffpa_pkg::ST_OK)
        begin
            r.gb = fx_base[i];
            if (fx_len[i] == n)
            begin
                for (int k = i; k + 1 < fx_cnt; k++)
                begin
                    fx_base[k] = fx_base[k+1];
                    fx_len[k] = fx_len[k+1];
                end
                fx_cnt--;
            end
            else
            begin
                fx_base[i] = fx_base[i] + n;
                fx_len[i] = fx_len[i] - n;
            end
            ux_base[ux_cnt] = r.gb;
            ux_len[ux_cnt] = n;
            ux_cnt++;
            pages_free = pages_free - n;
        end
        r.fp = pages_free;
        return r;
    endfunction

    function automatic word_t free_extent(logic [PAGE_W-1:0] b);
        word_t r;
        int j;
        int pos;
        logic [COUNT_W-1:0] len;
        bit lo_adj;
        bit hi_adj;
        r.st = ffpa_pkg::ST_OK;
        r.gb = '0;
        j = 0;
        pos = 0;
        while (j < ux_cnt && ux_base[j] != b)
            j++;
        if (j >= ux_cnt)
            r.st = ffpa_pkg::ST_UNKNOWN;
        else
        begin
            len = ux_len[j];
            while (pos < fx_cnt && fx_base[pos] <= b)
                pos++;
            lo_adj = pos > 0 && PAGE_W'(fx_base[pos-1] + fx_len[pos-1]) == b;
            hi_adj = pos < fx_cnt && PAGE_W'(b + len) == fx_base[pos];
            if (lo_adj && hi_adj)
            begin
                fx_len[pos-1] = fx_len[pos-1] + len + fx_len[pos];
                for (int k = pos; k + 1 < fx_cnt; k++)
                begin
                    fx_base[k] = fx_base[k+1];
                    fx_len[k] = fx_len[k+1];
                end
                fx_cnt--;
            end
            else if (lo_adj)
                fx_len[pos-1] = fx_len[pos-1] + len;
            else if (hi_adj)
            begin
                fx_base[pos] = b;
                fx_len[pos] = fx_len[pos] + len;
            end
            else if (fx_cnt >= NEXT)
                r.st = ffpa_pkg::ST_FULL;
            else
            begin
                for (int k = fx_cnt; k > pos; k--)
                begin
                    fx_base[k] = fx_base[k-1];
                    fx_len[k] = fx_len[k-1];
                end
                fx_base[pos] = b;
                fx_len[pos] = len;
                fx_cnt++;
            end
            if (r.st == ffpa_pkg::ST_OK)
            begin
                for (int k = j; k + 1 < ux_cnt; k++)
                begin
                    ux_base[k] = ux_base[k+1];
                    ux_len[k] = ux_len[k+1];
                end
                ux_cnt--;
                pages_free = pages_free + len;
            end
        end
        r.fp = pages_free;
        return r;
    endfunction

    // used extent with no free neighbor on either side, -1 if none
    function automatic int isolated_used();
        bit touch;
        for (int j = 0; j < ux_cnt; j++)
        begin
            touch = 0;
            for (int k = 0; k < fx_cnt; k++)
                if (PAGE_W'(fx_base[k] + fx_len[k]) == ux_base[j] ||
                    fx_base[k] == PAGE_W'(ux_base[j] + ux_len[j]))
                    touch = 1;
            if (!touch)
                return j;
        end
        return -1;
    endfunction

    task automatic send_word(input row_t r);
        word_t w;
        start <= 1'b1;
        command <= r.cmd;
        page_count <= r.cnt;
        base_page <= r.base;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        w = (r.cmd == ffpa_pkg::CMD_ALLOC) ? alloc_pages(r.cnt) : free_extent(r.base);
        pending_q.push_back(r.typed ? r.w : w);
        n_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic alloc_word(input logic [COUNT_W-1:0] n);
        row_t r;
        r = '{ffpa_pkg::CMD_ALLOC, n, PAGE_W'($urandom), 0, '{0, 0, 0}};
        send_word(r);
    endtask

    task automatic free_word(input logic [PAGE_W-1:0] b);
        row_t r;
        r = '{ffpa_pkg::CMD_FREE, COUNT_W'($urandom), b, 0, '{0, 0, 0}};
        send_word(r);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_region(input logic [PAGE_W-1:0] b, input logic [COUNT_W-1:0] p);
        cfg_we <= 1'b1;
        cfg_idx <= ffpa_pkg::REG_REGION_BASE;
        cfg_data <= b;
        @(posedge clk);
        cfg_idx <= ffpa_pkg::REG_REGION_PAGES;
        cfg_data <= PAGE_W'(p);
        @(posedge clk);
        cfg_we <= 1'b0;
        rgn_base = b;
        rgn_pages = p;
        tables_init();
    endtask

    always @(posedge clk)
    begin
        word_t e;
        if (rst_n && done)
        begin
            n_seen++;
            st_hits[status]++;
            if (pending_q.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("ERROR: unexpected result word, status %0d", status);
            end
            else
            begin
                e = pending_q.pop_front();
                if (e.st !== status || e.gb !== granted_base_page || e.fp !== free_total)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("ERROR: word %0d exp st=%0d gb=%h fp=%h got st=%0d gb=%h fp=%h",
                            n_seen, e.st, e.gb, e.fp, status, granted_base_page,
                            free_total);
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("first_fit_page_extent_allocator_tb: FAIL");
        $finish;
    end

    initial
    begin
        row_t dir [$];
        logic [PAGE_W-1:0] rb;
        logic [PAGE_W-1:0] pb [6];
        logic [COUNT_W-1:0] pp [6];
        int pi [6];
        int r;
        int j;
        logic [COUNT_W-1:0] cap;

        rb = ffpa_pkg::RESET_BASE_PAGE;
        rgn_base = ffpa_pkg::RESET_BASE_PAGE;
        rgn_pages = ffpa_pkg::RESET_REGION_PAGES;
        tables_init();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset region: count checks, whole-region grant, unknown bases, coalescing
        dir = '{
            '{ffpa_pkg::CMD_ALLOC, 29'd0, 52'd0, 1,
                '{ffpa_pkg::ST_ZERO, 52'd0, ffpa_pkg::RESET_REGION_PAGES}},
            '{ffpa_pkg::CMD_ALLOC, 29'h1FFF_FFFF, 52'd0, 1,
                '{ffpa_pkg::ST_TOO_FEW, 52'd0, ffpa_pkg::RESET_REGION_PAGES}},
            '{ffpa_pkg::CMD_ALLOC, ffpa_pkg::RESET_REGION_PAGES, 52'd0, 1,
                '{ffpa_pkg::ST_OK, ffpa_pkg::RESET_BASE_PAGE, 29'd0}},
            '{ffpa_pkg::CMD_ALLOC, 29'd1, 52'd0, 1,
                '{ffpa_pkg::ST_TOO_FEW, 52'd0, 29'd0}},
            '{ffpa_pkg::CMD_FREE, 29'd0, ffpa_pkg::RESET_BASE_PAGE, 1,
                '{ffpa_pkg::ST_OK, 52'd0, ffpa_pkg::RESET_REGION_PAGES}},
            '{ffpa_pkg::CMD_FREE, 29'd0, ffpa_pkg::RESET_BASE_PAGE, 1,
                '{ffpa_pkg::ST_UNKNOWN, 52'd0, ffpa_pkg::RESET_REGION_PAGES}},
            '{ffpa_pkg::CMD_FREE, 29'h1FFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 1,
                '{ffpa_pkg::ST_UNKNOWN, 52'd0, ffpa_pkg::RESET_REGION_PAGES}},
            '{ffpa_pkg::CMD_ALLOC, 29'd1, 52'd0, 0, '{0, 0, 0}},
            '{ffpa_pkg::CMD_ALLOC, 29'd100, 52'd0, 0, '{0, 0, 0}},
            '{ffpa_pkg::CMD_ALLOC, 29'd7, 52'd0, 0, '{0, 0, 0}},
            '{ffpa_pkg::CMD_FREE, 29'd0, rb + 1, 0, '{0, 0, 0}},
            '{ffpa_pkg::CMD_FREE, 29'd0, rb, 0, '{0, 0, 0}},
            '{ffpa_pkg::CMD_ALLOC, 29'd50, 52'd0, 0, '{0, 0, 0}},
            '{ffpa_pkg::CMD_FREE, 29'd0, rb + 101, 0, '{0, 0, 0}},
            '{ffpa_pkg::CMD_FREE, 29'd0, rb, 0, '{0, 0, 0}},
            '{ffpa_pkg::CMD_FREE, 29'd0, 52'd0, 0, '{0, 0, 0}}
        };
        foreach (dir[i])
            send_word(dir[i]);
        drain();

        pb = '{52'd0, 52'hF_FFFF_FFFF_FF80, PAGE_W'({$urandom, $urandom}),
               PAGE_W'({$urandom, $urandom}), 52'h12345, 52'h1000};
        pp = '{29'd1, 29'd300, 29'd0, 29'h1000_0000, 29'($urandom_range(64, 200)),
               29'd65536};
        pi = '{0, 53, 9, 53, 0, 9};
        for (int ph = 0; ph < 5; ph++)
        begin
            set_region(pb[ph], pp[ph]);
            idle_pct = pi[ph];
            cap = (pp[ph] > 16) ? pp[ph] / 8 : 29'd2;
            for (int n = 0; n < 90; n++)
            begin
                r = $urandom_range(99);
                if (r < 5)
                    alloc_word(29'd0);
                else if (r < 10)
                    alloc_word(29'($urandom));
                else if (r < 55)
                    alloc_word(29'($urandom_range(1, cap)));
                else if (r < 92 && ux_cnt > 0)
                    free_word(ux_base[$urandom_range(0, ux_cnt - 1)]);
                else
                    free_word(PAGE_W'({$urandom, $urandom}));
            end
            drain();
        end

        // fragment until the free table is full, then hit both full cases
        set_region(pb[5], pp[5]);
        idle_pct = pi[5];
        for (int n = 0; n < 400 && fx_cnt < NEXT; n++)
        begin
            if (ux_cnt < NEXT)
                alloc_word(29'(2 * fx_cnt + 1));
            else
            begin
                j = isolated_used();
                if (j < 0)
                    break;
                free_word(ux_base[j]);
            end
        end
        while (ux_cnt < NEXT && pages_free > 29'(2 * NEXT + 1))
            alloc_word(29'(2 * NEXT + 1));
        alloc_word(29'd1);
        j = isolated_used();
        if (j >= 0)
            free_word(ux_base[j]);
        drain();

        $display("Sent %0d request words, checked %0d result words over 7 region settings.",
            n_sent, n_seen);
        $display("Status mix: ok %0d zero %0d too-few %0d no-fit %0d unknown %0d full %0d",
            st_hits[0], st_hits[1], st_hits[2], st_hits[3], st_hits[4], st_hits[5]);
        if (n_err == 0 && pending_q.size() == 0)
            $display("first_fit_page_extent_allocator_tb: PASS");
        else
            $display("first_fit_page_extent_allocator_tb: FAIL");
        $finish;
    end

endmodule
